FILE: sv/hmx_pkg.sv
// Shared types, constants and saturation helpers for the high-pass crossfade block.
package hmx_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int ST_W     = 48;
  localparam int EXT_W    = 52;
  localparam int ACC_W    = 80;
  localparam int OPA_W    = 33;
  localparam int OPB_W    = 25;
  localparam int MIX_W    = 25;
  localparam int ADDR_W   = 5;

  localparam logic [MIX_W-1:0] MIX_ONE = 25'h100_0000;

  // Mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_LOW_B0  = 3'd0;
  localparam logic [2:0] REG_LOW_A1  = 3'd1;
  localparam logic [2:0] REG_LOW_A2  = 3'd2;
  localparam logic [2:0] REG_HIGH_B0 = 3'd3;
  localparam logic [2:0] REG_HIGH_A1 = 3'd4;
  localparam logic [2:0] REG_HIGH_A2 = 3'd5;
  localparam logic [2:0] REG_FADE    = 3'd6;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    coef_t             low;
    coef_t             high;
    logic [MIX_W-1:0]  fade_step;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic hi;
  } mul_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PATH, S_LO, S_HI, S_MIX, S_MIXR, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    TERM_B0, TERM_A1, TERM_A2
  } term_e;

  function automatic logic signed [ST_W-1:0] sat48(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = 52'sh0_7FFF_FFFF_FFFF;
    lo = -52'sh0_8000_0000_0000;
    if (v > hi) sat48 = hi[ST_W-1:0];
    else if (v < lo) sat48 = lo[ST_W-1:0];
    else sat48 = v[ST_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp24(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = 52'sd8388607;
    lo = -52'sd8388608;
    if (v > hi) clamp24 = hi[SAMPLE_W-1:0];
    else if (v < lo) clamp24 = lo[SAMPLE_W-1:0];
    else clamp24 = v[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: sv/hmx_regs.sv
// APB configuration registers: coefficient sets and fade step.
module hmx_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmx_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hmx_pkg::cfg_t              cfg_o
);
  import hmx_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low.b0    <= 32'sd1065820800;
      cfg_q.low.a1    <= -32'sd2131582848;
      cfg_q.low.a2    <= 32'sd1057956800;
      cfg_q.high.b0   <= 32'sd1059917800;
      cfg_q.high.a1   <= -32'sd2119656648;
      cfg_q.high.a2   <= 32'sd1046271200;
      cfg_q.fade_step <= 25'd17476;
    end else if (wr) begin
      unique case (idx)
        REG_LOW_B0:  cfg_q.low.b0    <= pwdata;
        REG_LOW_A1:  cfg_q.low.a1    <= pwdata;
        REG_LOW_A2:  cfg_q.low.a2    <= pwdata;
        REG_HIGH_B0: cfg_q.high.b0   <= pwdata;
        REG_HIGH_A1: cfg_q.high.a1   <= pwdata;
        REG_HIGH_A2: cfg_q.high.a2   <= pwdata;
        REG_FADE:    cfg_q.fade_step <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_LOW_B0:  prdata = cfg_q.low.b0;
      REG_LOW_A1:  prdata = cfg_q.low.a1;
      REG_LOW_A2:  prdata = cfg_q.low.a2;
      REG_HIGH_B0: prdata = cfg_q.high.b0;
      REG_HIGH_A1: prdata = cfg_q.high.a1;
      REG_HIGH_A2: prdata = cfg_q.high.a2;
      REG_FADE:    prdata = {7'd0, cfg_q.fade_step};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

FILE: sv/hmx_mul.sv
// Shared 33x25 signed multiplier with an 80-bit accumulator for split operands.
module hmx_mul (
  input  logic                             clk_i,
  input  hmx_pkg::mul_ctl_t                ctl_i,
  input  logic signed [hmx_pkg::OPA_W-1:0] op_a_i,
  input  logic signed [hmx_pkg::OPB_W-1:0] op_b_i,
  output logic signed [hmx_pkg::ACC_W-1:0] acc_o
);
  import hmx_pkg::*;

  logic signed [OPA_W+OPB_W-1:0] prod;
  logic signed [ACC_W-1:0]       prod_x;
  logic signed [ACC_W-1:0]       acc_d;
  logic signed [ACC_W-1:0]       acc_q;

  // high half of the data operand is weighted by 2^24
  assign prod   = op_a_i * op_b_i;
  assign prod_x = ctl_i.hi ? (ACC_W'(prod) <<< 24) : ACC_W'(prod);
  assign acc_d  = (ctl_i.clear ? '0 : acc_q) + prod_x;
  // while enabled the sum includes this cycle's product, else the held value
  assign acc_o  = ctl_i.en ? acc_d : acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end
endmodule

FILE: sv/highpass_mode_crossfade.sv
// Top level: switchable two-section high-pass with linear crossfade between modes.
//
// Each sample runs through one shared multiplier under a small sequencer. A filter
// product is split into low and high halves of the 48-bit operand, three products
// per biquad section and two sections per path. During a crossfade both paths run and
// a mix multiply follows. A mode request transaction is taken while the block is idle
// and returns no result. The input is not ready while a sample is being worked on.
module highpass_mode_crossfade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hmx_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic signed [hmx_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [1:0]                          mode_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hmx_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                in_transition_o
);
  import hmx_pkg::*;

  cfg_t     cfg;
  mul_ctl_t mctl;
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [ACC_W-1:0] acc;

  state_e state_q, state_d;
  term_e  term_q;
  logic   path_q, sec_q;
  logic [1:0] active_q, pending_q;
  logic   fading_q;
  logic [MIX_W-1:0] mix_q;
  logic signed [ST_W-1:0] st_q [2][4];
  logic signed [SAMPLE_W-1:0] x_q, ya_q, yb_q, res_q, out_q;
  logic trans_q, out_tr_q, out_valid_q;
  logic signed [ST_W-1:0] v_q, bx_q, y_q;

  logic accept;
  logic [1:0] path_mode;
  logic filt;
  coef_t cs;
  logic signed [COEF_W-1:0] coef;
  logic signed [ST_W-1:0] vop, st_rd, p48, y_new, s0_new, s1_new;
  logic [1:0] rd_idx, wr_idx;
  logic path_done;
  logic signed [SAMPLE_W-1:0] path_val, rnd, mixed;
  logic signed [EXT_W-1:0] mix_t;
  logic signed [ACC_W-1:0] acc_r;
  logic [MIX_W-1:0] step_eff;
  logic [MIX_W:0] mix_sum;
  logic out_free;

  hmx_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  hmx_mul u_mul (.clk_i, .ctl_i(mctl), .op_a_i(op_a), .op_b_i(op_b), .acc_o(acc));

  assign in_ready_o      = (state_q == S_IDLE);
  assign accept          = in_valid_i && in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;
  assign in_transition_o = out_tr_q;
  assign out_free        = !out_valid_q || out_ready_i;

  // coefficient and operand selection
  assign path_mode = path_q ? pending_q : active_q;
  assign filt      = (path_mode == MODE_LOW) || (path_mode == MODE_HIGH);
  assign cs        = (path_mode == MODE_LOW) ? cfg.low : cfg.high;
  always_comb begin
    unique case (term_q)
      TERM_B0: coef = cs.b0;
      TERM_A1: coef = cs.a1;
      default: coef = cs.a2;
    endcase
  end
  assign vop = (term_q == TERM_B0) ? v_q : y_q;

  // multiplier control
  always_comb begin
    mctl = '0;
    op_a = OPA_W'(coef);
    op_b = {1'b0, vop[23:0]};
    unique case (state_q)
      S_LO: begin
        mctl.en    = 1'b1;
        mctl.clear = 1'b1;
      end
      S_HI: begin
        mctl.en = 1'b1;
        mctl.hi = 1'b1;
        op_b    = OPB_W'($signed(vop[ST_W-1:24]));
      end
      S_MIX: begin
        mctl.en    = 1'b1;
        mctl.clear = 1'b1;
        op_a       = OPA_W'({1'b0, mix_q});
        op_b       = OPB_W'(yb_q) - OPB_W'(ya_q);
      end
      default: ;
    endcase
  end

  // section arithmetic
  assign rd_idx = {sec_q, term_q == TERM_A1};
  assign wr_idx = {sec_q, term_q == TERM_A2};
  assign st_rd  = st_q[path_q][rd_idx];
  assign p48    = sat48(EXT_W'($signed(acc[ACC_W-1:30])));
  assign y_new  = sat48(EXT_W'(p48) + EXT_W'(st_rd));
  assign s0_new = sat48(-(EXT_W'(bx_q) <<< 1) - EXT_W'(p48) + EXT_W'(st_rd));
  assign s1_new = sat48(EXT_W'(bx_q) - EXT_W'(p48));
  assign rnd    = clamp24((EXT_W'(y_q) + 52'sd32768) >>> 16);

  // crossfade: a + floor((m*(b-a) + 2^23) / 2^24)
  assign acc_r = acc + 80'sd8388608;
  assign mix_t = EXT_W'(ya_q) + $signed(acc_r[75:24]);
  assign mixed = clamp24(mix_t);

  assign step_eff = (cfg.fade_step == '0) ? MIX_W'(1) : cfg.fade_step;
  assign mix_sum  = {1'b0, mix_q} + {1'b0, step_eff};

  // end of a path: bypassed or after the second section
  always_comb begin
    path_done = 1'b0;
    path_val  = rnd;
    if (state_q == S_PATH && !filt) begin
      path_done = 1'b1;
      path_val  = x_q;
    end else if (state_q == S_HI && term_q == TERM_A2 && sec_q) begin
      path_done = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && !operation_i) state_d = S_PATH;
      S_PATH: if (filt) state_d = S_LO;
      S_LO:   state_d = S_HI;
      S_HI:   if (!path_done) state_d = S_LO;
      S_MIX:  state_d = S_MIXR;
      S_MIXR: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (path_done) begin
      if (path_q) state_d = S_MIX;
      else if (fading_q) state_d = S_PATH;
      else state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // control state and filter delays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= MODE_OFF;
      pending_q   <= MODE_OFF;
      fading_q    <= 1'b0;
      mix_q       <= '0;
      path_q      <= 1'b0;
      sec_q       <= 1'b0;
      term_q      <= TERM_B0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        for (int i = 0; i < 4; i++) st_q[p][i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && operation_i) begin
            if (mode_request_i != MODE_BAD && mode_request_i != active_q) begin
              pending_q <= mode_request_i;
              fading_q  <= 1'b1;
              mix_q     <= '0;
              for (int i = 0; i < 4; i++) st_q[1][i] <= '0;
            end
          end else if (accept) begin
            path_q <= 1'b0;
            if (fading_q) mix_q <= (mix_sum > {1'b0, MIX_ONE}) ? MIX_ONE : mix_sum[MIX_W-1:0];
          end
        end
        S_PATH: begin
          sec_q  <= 1'b0;
          term_q <= TERM_B0;
        end
        S_HI: begin
          unique case (term_q)
            TERM_B0: term_q <= TERM_A1;
            TERM_A1: begin
              st_q[path_q][wr_idx] <= s0_new;
              term_q <= TERM_A2;
            end
            default: begin
              st_q[path_q][wr_idx] <= s1_new;
              term_q <= TERM_B0;
              sec_q  <= 1'b1;
            end
          endcase
        end
        S_MIXR: begin
          if (mix_q == MIX_ONE) begin
            for (int i = 0; i < 4; i++) st_q[0][i] <= '0;
            active_q <= pending_q;
            fading_q <= 1'b0;
            mix_q    <= '0;
          end
        end
        default: ;
      endcase
      // result valid: set on a new result, cleared when taken
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (path_done && !path_q && fading_q) path_q <= 1'b1;
    end
  end

  // sample datapath
  always_ff @(posedge clk_i) begin
    if (accept) x_q <= sample_in_i;
    if (state_q == S_PATH && filt) v_q <= {{8{x_q[SAMPLE_W-1]}}, x_q, 16'd0};
    if (state_q == S_HI) begin
      if (term_q == TERM_B0) begin
        bx_q <= p48;
        y_q  <= y_new;
      end
      if (term_q == TERM_A2 && !sec_q) v_q <= y_q;
    end
    if (path_done) begin
      if (path_q) yb_q <= path_val;
      else begin
        ya_q    <= path_val;
        res_q   <= path_val;
        trans_q <= 1'b0;
      end
    end
    if (state_q == S_MIXR) begin
      res_q   <= mixed;
      trans_q <= (mix_q != MIX_ONE);
    end
    if (state_q == S_OUT && out_free) begin
      out_q    <= res_q;
      out_tr_q <= trans_q;
    end
  end

  // checks
  a_mix_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fading_q |-> mix_q == '0) else $error("mix level nonzero outside a fade");
  a_mix_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_q <= MIX_ONE) else $error("mix level above one");
  a_pend_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fading_q |-> pending_q != MODE_BAD) else $error("fade toward undefined mode");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LO) |=> (state_q == S_HI)) else $error("split multiply broken");
endmodule

FILE: dv/tb.sv
// Self-checking testbench for the switchable high-pass with crossfade between modes.
module tb;
  import hmx_pkg::*;

  localparam int  OP_SAMPLE   = 0;
  localparam int  OP_MODE     = 1;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_WAIT  = 60;
  localparam int  HOLD_LEN    = 600;
  localparam longint ST_HI    = (64'sd1 <<< 47) - 1;
  localparam longint ST_LO    = -(64'sd1 <<< 47);
  localparam longint MIX_FULL = 64'sd1 <<< 24;

  typedef struct {
    bit                      op;
    logic signed [SAMPLE_W-1:0] smp;
    logic [1:0]              mode;
  } audio_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       fade;
  } audio_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic op_in = 0;
  logic signed [SAMPLE_W-1:0] smp_in = '0;
  logic [1:0] mode_in = '0;
  logic out_valid, out_ready = 0;
  logic signed [SAMPLE_W-1:0] smp_out;
  logic fade_out;

  highpass_mode_crossfade i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op_in), .sample_in_i(smp_in), .mode_request_i(mode_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .sample_out_o(smp_out), .in_transition_o(fade_out)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Filter model state and register shadow
  longint     coef[6];
  logic [MIX_W-1:0] step_reg;
  longint     cur_st[4];
  longint     new_st[4];
  logic [1:0] cur_mode, next_mode;
  bit         fading;
  longint     mix;

  audio_item_t   pend_q[$];
  audio_result_t result_q[$];
  int errors = 0;
  int n_accepted = 0, n_results = 0, n_mode_req = 0, n_fade_out = 0;
  int cycles = 0;

  // floor(c * v / 2^30), saturated to 48 bits
  function automatic longint coef_mul(longint c, longint v);
    logic signed [95:0] pc, pv, p;
    pc = c;
    pv = v;
    p = (pc * pv) >>> 30;
    if (p > ST_HI) return ST_HI;
    if (p < ST_LO) return ST_LO;
    return longint'(p);
  endfunction

  function automatic longint sat_st(longint v);
    return v > ST_HI ? ST_HI : (v < ST_LO ? ST_LO : v);
  endfunction

  function automatic longint sat_smp(longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  // Transposed direct form II biquad, b1 = -2*b0 and b2 = b0
  function automatic longint biquad(ref longint st[4], input int base, input int cb,
                                    input longint x);
    longint bx, y;
    bx = coef_mul(coef[cb], x);
    y = sat_st(bx + st[base]);
    st[base] = sat_st(-2 * bx - coef_mul(coef[cb+1], y) + st[base+1]);
    st[base+1] = sat_st(bx - coef_mul(coef[cb+2], y));
    return y;
  endfunction

  function automatic longint filter_path(ref longint st[4], input logic [1:0] m,
                                         input longint x);
    longint v;
    int cb;
    if (m != MODE_LOW && m != MODE_HIGH) return x;
    cb = (m == MODE_LOW) ? 0 : 3;
    v = biquad(st, 0, cb, x <<< 16);
    v = biquad(st, 2, cb, v);
    return sat_smp((v + (64'sd1 <<< 15)) >>> 16);
  endfunction

  // Advance the model by one accepted transaction
  function automatic void hp_predict(audio_item_t it);
    longint x, ya, yb, y;
    audio_result_t r;
    if (it.op == OP_MODE) begin
      if (it.mode == MODE_BAD || it.mode == cur_mode) return;
      next_mode = it.mode;
      foreach (new_st[i]) new_st[i] = 0;
      mix = 0;
      fading = 1;
      return;
    end
    x = it.smp;
    if (!fading) begin
      y = filter_path(cur_st, cur_mode, x);
    end else begin
      mix += (step_reg != 0) ? longint'(step_reg) : 1;
      if (mix > MIX_FULL) mix = MIX_FULL;
      ya = filter_path(cur_st, cur_mode, x);
      yb = filter_path(new_st, next_mode, x);
      y = sat_smp(((MIX_FULL - mix) * ya + mix * yb + (MIX_FULL >>> 1)) >>> 24);
      if (mix >= MIX_FULL) begin
        foreach (cur_st[i]) cur_st[i] = 0;
        cur_mode = next_mode;
        fading = 0;
        mix = 0;
      end
    end
    r.smp = y[SAMPLE_W-1:0];
    r.fade = fading;
    result_q.push_back(r);
  endfunction

  // Driver: bursts of transactions with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    audio_item_t it;
    if (in_valid && in_ready) begin
      hp_predict('{op_in, smp_in, mode_in});
      n_accepted++;
      if (op_in == OP_MODE) n_mode_req++;
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (pend_q.size() > 0) begin
        it = pend_q.pop_front();
        in_valid <= 1;
        op_in <= it.op;
        smp_in <= it.smp;
        mode_in <= it.mode;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Long receiver hold-off, started once 300 transactions have been accepted
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!hold_done && n_accepted >= 300) begin
      hold_done = 1;
      hold_left = HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Receiver stall pattern: always ready, random, or mostly stalled, chosen at random
  int stall_kind = 0;
  always @(posedge clk) begin
    bit rdy;
    if (cycles % 64 == 0) stall_kind = $urandom_range(0, 2);
    case (stall_kind)
      0: rdy = 1;
      1: rdy = $urandom_range(0, 1);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    out_ready <= rdy && (hold_left == 0) && hold_done | (rdy && !hold_done);
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    audio_result_t want;
    if (out_valid && out_ready) begin
      n_results++;
      if (fade_out) n_fade_out++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample_out=%0d in_transition=%0b",
                 $time, smp_out, fade_out);
      end else begin
        want = result_q.pop_front();
        if (smp_out !== want.smp) begin
          errors++;
          $display("%0t: sample_out expected %0d actual %0d", $time, want.smp, smp_out);
        end
        if (fade_out !== want.fade) begin
          errors++;
          $display("%0t: in_transition expected %0b actual %0b",
                   $time, want.fade, fade_out);
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx < 6) coef[idx] = longint'($signed(val));
    else step_reg = val[MIX_W-1:0];
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void add_sample(logic signed [SAMPLE_W-1:0] s);
    pend_q.push_back('{OP_SAMPLE, s, 2'($urandom_range(0, 3))});
  endfunction

  function automatic void add_mode(logic [1:0] m);
    pend_q.push_back('{OP_MODE, 24'($urandom), m});
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 255)) - 24'sd128;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic void add_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) add_mode(2'($urandom_range(0, 3)));
      else add_sample(rand_sample());
    end
  endfunction

  task automatic set_coefs(logic [31:0] v[7]);
    for (int i = 0; i < 7; i++) reg_write(i, v[i]);
  endtask

  initial begin
    coef = '{1065820800, -2131582848, 1057956800, 1059917800, -2119656648, 1046271200};
    step_reg = 17476;
    foreach (cur_st[i]) begin
      cur_st[i] = 0;
      new_st[i] = 0;
    end
    cur_mode = MODE_OFF;
    next_mode = MODE_OFF;
    fading = 0;
    mix = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, same mode, undefined mode, restart during fade
    add_sample(24'sh7FFFFF);
    add_sample(24'sh800000);
    add_sample(0);
    add_sample(-1);
    add_mode(MODE_OFF);
    add_mode(MODE_BAD);
    add_sample(24'sh400000);
    add_mode(MODE_LOW);
    add_sample(24'sh7FFFFF);
    add_sample(24'sh800000);
    add_mode(MODE_HIGH);
    add_sample(24'sh123456);
    add_mode(MODE_HIGH);
    add_sample(-24'sd5);
    add_mode(MODE_OFF);
    add_sample(24'sh7FFFFF);
    wait_idle();

    // Full-scale step: every fade ends on its first sample
    reg_write(6, 32'h100_0000);
    add_mode(MODE_LOW);
    add_sample(24'sh800000);
    add_sample(24'sh7FFFFF);
    add_mode(MODE_HIGH);
    add_sample(24'sh7FFFFF);
    add_sample(1);
    add_random(100);
    wait_idle();

    // Largest and most negative coefficients drive the internal states into saturation
    set_coefs('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h40_0000});
    add_mode(MODE_LOW);
    add_random(110);
    wait_idle();

    // Random coefficients, medium step
    set_coefs('{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                32'($urandom_range(1, 1 << 22))});
    add_random(110);
    wait_idle();

    // Nominal filters, smallest step: fades run through the whole phase
    set_coefs('{32'd1065820800, -32'sd2131582848, 32'd1057956800,
                32'd1059917800, -32'sd2119656648, 32'd1046271200, 32'd1});
    add_mode(MODE_HIGH);
    add_random(110);
    wait_idle();

    // Nominal filters, quick fades
    reg_write(6, 32'($urandom_range(1 << 21, 1 << 23)));
    add_random(110);
    wait_idle();

    $display("Ran %0d transactions (%0d mode requests), checked %0d results,",
             n_accepted, n_mode_req, n_results);
    $display("%0d of them during a crossfade, over six register settings", n_fade_out);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
